// File: rtl/core/ale_pkg.sv
// Shared types and codes for the array list engine.
package ale_pkg;

    // Fixed field widths of the command and result beats.
    localparam int POS_W = 7;
    localparam int CMD_W = 3;
    localparam int STATUS_W = 2;
    localparam int DATA_W = 32;
    localparam int LEN_W = 8;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REPLACE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd6;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ERR  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

    // Command beat.
    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] item_value;
    } ale_in_t;

    // Result beat.
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] result_value;
        logic [POS_W-1:0]         found_position;
        logic [LEN_W-1:0]         list_length;
    } ale_out_t;

    // Per-cycle control broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic del;
        logic app;
        logic rep;
        logic clr;
        logic load;
        logic shift;
    } ale_cell_ctrl_t;

endpackage

// File: rtl/core/ale_cell.sv
// One list cell: a stored entry plus a scan lane stage.
module ale_cell #(
    parameter int VALUE_WIDTH = 32,
    parameter int CNT_W = 8,
    parameter int INDEX = 0
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  ale_pkg::ale_cell_ctrl_t    ctrl,
    input  logic [ale_pkg::POS_W-1:0]  pos_i,
    input  logic [CNT_W-1:0]           cnt_i,
    input  logic [VALUE_WIDTH-1:0]     wval_i,
    input  logic [VALUE_WIDTH-1:0]     left_i,
    input  logic [VALUE_WIDTH-1:0]     right_i,
    input  logic [VALUE_WIDTH-1:0]     lane_right_i,
    output logic [VALUE_WIDTH-1:0]     entry_o,
    output logic [VALUE_WIDTH-1:0]     lane_o
);

    localparam int CMP_W = (CNT_W > ale_pkg::POS_W) ? CNT_W : ale_pkg::POS_W;
    localparam logic [CMP_W-1:0] K = CMP_W'(INDEX);
    localparam logic [CMP_W-1:0] K_PLUS1 = CMP_W'(INDEX + 1);

    logic [VALUE_WIDTH-1:0] entry_reg;
    logic [VALUE_WIDTH-1:0] entry_next;
    logic [VALUE_WIDTH-1:0] lane_reg;
    logic [VALUE_WIDTH-1:0] lane_next;
    logic [CMP_W-1:0]       pos_ext;
    logic [CMP_W-1:0]       cnt_ext;

    assign pos_ext = CMP_W'(pos_i);
    assign cnt_ext = CMP_W'(cnt_i);

    // Entry update: each operation picks this cell's own value, a neighbor's, the new one, or zero.
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.clr) begin
            entry_next = '0;
        end else if (ctrl.ins) begin
            if (K == pos_ext) begin
                entry_next = wval_i;
            end else if (K > pos_ext && K <= cnt_ext) begin
                entry_next = left_i;
            end
        end else if (ctrl.del) begin
            if (K_PLUS1 == cnt_ext) begin
                entry_next = '0;
            end else if (K >= pos_ext && K_PLUS1 < cnt_ext) begin
                entry_next = right_i;
            end
        end else if (ctrl.app) begin
            if (K == cnt_ext) begin
                entry_next = wval_i;
            end
        end else if (ctrl.rep) begin
            if (K == pos_ext) begin
                entry_next = wval_i;
            end
        end
    end

    // Scan lane: takes a copy of the entry, then moves toward cell zero one step a cycle.
    always_comb begin
        lane_next = lane_reg;
        if (ctrl.load) begin
            lane_next = entry_reg;
        end else if (ctrl.shift) begin
            lane_next = lane_right_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
        end else begin
            entry_reg <= entry_next;
        end
        lane_reg <= lane_next;
    end

    assign entry_o = entry_reg;
    assign lane_o = lane_reg;

endmodule

// File: rtl/core/array_list_engine.sv
// Top level of the array list engine: command control, cell chain and result register.
//
//  Channel   Ports                     Beat
//  command   s_valid s_ready s_data    ale_in_t: command, position, item_value
//  result    m_valid m_ready m_data    ale_out_t: status, result_value, found_position,
//                                      list_length
//
// Insert, append, replace, clear and every rejected command finish without a scan. Read
// and delete scan up to the entry at pos; a search scans up to a match at or after pos,
// or to the last entry on a miss: the scan lane of the cell chain moves one entry per cycle.
// Reset is synchronous on aresetn and clears the whole store and the length at once.
// A command is taken only while no scan runs and the result register is free or being drained.
module array_list_engine #(
    parameter int CAPACITY = 128,
    parameter int VALUE_WIDTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ale_pkg::ale_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ale_pkg::ale_out_t m_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > ale_pkg::POS_W) ? CNT_W : ale_pkg::POS_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic {
        IDLE,
        SCAN
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic                           m_valid_reg;
    logic                           m_valid_next;
    ale_pkg::ale_out_t              m_data_reg;
    ale_pkg::ale_out_t              m_data_next;
    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               count_next;
    logic [IDX_W-1:0]               idx_reg;
    logic [IDX_W-1:0]               idx_next;
    logic [ale_pkg::CMD_W-1:0]      op_reg;
    logic [ale_pkg::CMD_W-1:0]      op_next;
    logic [ale_pkg::POS_W-1:0]      pos_reg;
    logic [ale_pkg::POS_W-1:0]      pos_next;
    logic [VALUE_WIDTH-1:0]         val_reg;
    logic [VALUE_WIDTH-1:0]         val_next;

    logic                           accept;
    logic [VALUE_WIDTH-1:0]         in_val;
    logic [CMP_W-1:0]               pos_ext;
    logic [CMP_W-1:0]               cnt_ext;
    logic [CMP_W-1:0]               idx_ext;
    logic [CMP_W-1:0]               scan_pos_ext;
    logic                           full;
    logic                           in_range;
    logic                           ok_now;
    logic                           scan_cmd;
    logic                           scan_match;
    logic                           scan_last;
    logic                           scan_done;
    ale_pkg::ale_cell_ctrl_t        cell_ctrl;

    logic [VALUE_WIDTH-1:0]         cell_entry [CAPACITY];
    logic [VALUE_WIDTH-1:0]         cell_lane [CAPACITY];

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == IDLE) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    // Command decode and range checks against the current length.
    assign in_val = VALUE_WIDTH'(s_data.item_value);
    assign pos_ext = CMP_W'(s_data.position);
    assign cnt_ext = CMP_W'(count_reg);
    assign full = (count_reg == CAP_CNT);
    assign in_range = (pos_ext < cnt_ext);
    assign scan_cmd = (s_data.command == ale_pkg::CMD_DELETE)
                   || (s_data.command == ale_pkg::CMD_READ)
                   || (s_data.command == ale_pkg::CMD_SEARCH);

    always_comb begin
        unique case (s_data.command)
            ale_pkg::CMD_INSERT:  ok_now = (pos_ext <= cnt_ext) && !full;
            ale_pkg::CMD_APPEND:  ok_now = !full;
            ale_pkg::CMD_REPLACE: ok_now = in_range;
            ale_pkg::CMD_CLEAR:   ok_now = 1'b1;
            default:              ok_now = 1'b0;
        endcase
    end

    // Scan checks: lane cell zero holds the entry at idx_reg.
    // Only a search may stop at the last entry without a match.
    assign idx_ext = CMP_W'(idx_reg);
    assign scan_pos_ext = CMP_W'(pos_reg);
    assign scan_match = (op_reg == ale_pkg::CMD_SEARCH)
                      ? (idx_ext >= scan_pos_ext && cell_lane[0] == val_reg)
                      : (idx_ext == scan_pos_ext);
    assign scan_last = (op_reg == ale_pkg::CMD_SEARCH)
                    && ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign scan_done = (state_reg == SCAN) && (scan_match || scan_last);

    // Control broadcast to the chain.
    always_comb begin
        cell_ctrl.ins = accept && (s_data.command == ale_pkg::CMD_INSERT) && ok_now;
        cell_ctrl.del = accept && (s_data.command == ale_pkg::CMD_DELETE) && in_range;
        cell_ctrl.app = accept && (s_data.command == ale_pkg::CMD_APPEND) && ok_now;
        cell_ctrl.rep = accept && (s_data.command == ale_pkg::CMD_REPLACE) && ok_now;
        cell_ctrl.clr = accept && (s_data.command == ale_pkg::CMD_CLEAR);
        cell_ctrl.load = accept && scan_cmd && in_range;
        cell_ctrl.shift = (state_reg == SCAN) && !scan_match && !scan_last;
    end

    // Next state, length and result beat.
    always_comb begin
        state_next = state_reg;
        m_valid_next = m_valid_reg;
        m_data_next = m_data_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        op_next = op_reg;
        pos_next = pos_reg;
        val_next = val_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            if (cell_ctrl.ins || cell_ctrl.app) begin
                count_next = count_reg + CNT_W'(1);
            end else if (cell_ctrl.del) begin
                count_next = count_reg - CNT_W'(1);
            end else if (cell_ctrl.clr) begin
                count_next = '0;
            end

            if (cell_ctrl.load) begin
                // Read, delete and search finish through the scan.
                state_next = SCAN;
                idx_next = '0;
                op_next = s_data.command;
                pos_next = s_data.position;
                val_next = in_val;
            end else begin
                m_valid_next = 1'b1;
                m_data_next.status = ok_now ? ale_pkg::ST_OK : ale_pkg::ST_ERR;
                m_data_next.result_value = '0;
                m_data_next.found_position = '0;
                m_data_next.list_length = ale_pkg::LEN_W'(count_next);
            end
        end else if (scan_done) begin
            // The result register is always empty while a scan runs.
            state_next = IDLE;
            m_valid_next = 1'b1;
            m_data_next.list_length = ale_pkg::LEN_W'(count_reg);
            if (op_reg == ale_pkg::CMD_SEARCH) begin
                m_data_next.result_value = '0;
                if (scan_match) begin
                    m_data_next.status = ale_pkg::ST_OK;
                    m_data_next.found_position = ale_pkg::POS_W'(idx_reg);
                end else begin
                    m_data_next.status = ale_pkg::ST_MISS;
                    m_data_next.found_position = '0;
                end
            end else begin
                m_data_next.status = ale_pkg::ST_OK;
                m_data_next.result_value = ale_pkg::DATA_W'($signed(cell_lane[0]));
                m_data_next.found_position = '0;
            end
        end else if (cell_ctrl.shift) begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            m_valid_reg <= 1'b0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
            count_reg <= count_next;
        end
        m_data_reg <= m_data_next;
        idx_reg <= idx_next;
        op_reg <= op_next;
        pos_reg <= pos_next;
        val_reg <= val_next;
    end

    // The chain of cells, one per list entry.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [VALUE_WIDTH-1:0] left_w;
        logic [VALUE_WIDTH-1:0] right_w;
        logic [VALUE_WIDTH-1:0] lane_right_w;

        if (k == 0) begin : g_head
            assign left_w = '0;
        end else begin : g_body
            assign left_w = cell_entry[k-1];
        end

        if (k == CAPACITY - 1) begin : g_tail
            assign right_w = '0;
            assign lane_right_w = '0;
        end else begin : g_inner
            assign right_w = cell_entry[k+1];
            assign lane_right_w = cell_lane[k+1];
        end

        ale_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .CNT_W       (CNT_W),
            .INDEX       (k)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl         (cell_ctrl),
            .pos_i        (s_data.position),
            .cnt_i        (count_reg),
            .wval_i       (in_val),
            .left_i       (left_w),
            .right_i      (right_w),
            .lane_right_i (lane_right_w),
            .entry_o      (cell_entry[k]),
            .lane_o       (cell_lane[k])
        );
    end

    // The length never exceeds the store.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("list length beyond capacity");

    // The result register stays empty for the whole scan.
    a_scan_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == SCAN |-> !m_valid_reg)
        else $error("result pending during scan");

    // A search scan never walks past the last entry.
    a_search_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SCAN && op_reg == ale_pkg::CMD_SEARCH) |-> idx_ext < cnt_ext)
        else $error("search scan beyond list end");

    // A clear leaves an empty list with a result pending.
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.command == ale_pkg::CMD_CLEAR) |=> (count_reg == '0 && m_valid_reg))
        else $error("clear did not empty the list");

endmodule
